// ===== src/timestamped_box_history_rewind_assert.svh =====
// ----------------------------------------------------------------------------
// timestamped_box_history_rewind_assert
// Assertion macros used by the history ring module.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMPED_BOX_HISTORY_REWIND_ASSERT_SVH
`define TIMESTAMPED_BOX_HISTORY_REWIND_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define TBHR_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define TBHR_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

// ===== src/tbhr_pkg.sv =====
// ----------------------------------------------------------------------------
// tbhr_pkg
// Shared types and constants of the timestamped box history ring.
// ----------------------------------------------------------------------------
`default_nettype none
package tbhr_pkg;
    localparam int RING_DEPTH_DEF    = 16;
    localparam int COORD_BITS_DEF    = 21;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int OUT_W  = 21;
    localparam int TIME_W = 31;
    localparam int NCOORD = 9;

    // Command codes. The spare code is accepted, leaves the ring unchanged and gives a zero result with status none.
    localparam logic [1:0] CMD_STORE  = 2'd0;
    localparam logic [1:0] CMD_RESET  = 2'd1;
    localparam logic [1:0] CMD_REWIND = 2'd2;
    localparam logic [1:0] CMD_SPARE  = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_INTERP = 2'd1;
    localparam logic [1:0] ST_OLDEST = 2'd2;

    // Divider request and reply between sequencer and divider.
    typedef struct packed {
        logic        start;
        logic [31:0] den;
        logic [31:0] num_hi;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;
endpackage
`default_nettype wire

// ===== src/timestamped_box_history_rewind.sv =====
// Per item: a store writes the next slot; a ring reset writes every slot, one
// slot written per cycle; a rewind probes slots from the newest backwards, each
// probe an address step and then a registered read and compare. When no slot
// qualifies, the newest slot is probed once more before the oldest is read. An
// interpolating rewind also runs the divider and then the shared blend
// multiplier, with a multiply step and an accumulate step per coordinate. The
// input is not ready while an item is in work or while its result waits, so a
// stalled receiver stalls the input. There is no clearing pass: after reset the
// ring reads as all zero via a fill flag per slot.
// ----------------------------------------------------------------------------
// timestamped_box_history_rewind
// Ring of timestamped boxes with rewind by fixed-point interpolation.
// ----------------------------------------------------------------------------
`default_nettype none
module timestamped_box_history_rewind
    import tbhr_pkg::*;
#(
    parameter int RING_DEPTH    = RING_DEPTH_DEF,
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // query_time[30:0], current_time[61:31], origin_x/y/z, low_x/y/z,
    // high_x/y/z (21 bits each) from bit 62 up, zero filled to 256 bits
    input  wire logic [255:0]  s_tdata,
    // command
    input  wire logic [1:0]    s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // out_origin_x/y/z, out_low_x/y/z, out_high_x/y/z (21 bits each), zero fill
    output logic [191:0]       m_tdata,
    // status
    output logic [1:0]         m_tuser
);
    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int EW = TIME_W + NCOORD * COORD_BITS;
    localparam int PW = COORD_BITS + FRACTION_BITS + 2;

    localparam logic [3:0] S_IDLE = 4'd0, S_RST = 4'd1, S_RD = 4'd2,
                           S_CHK = 4'd3, S_RDJ = 4'd4, S_DIV = 4'd5,
                           S_MUL = 4'd6, S_ACC = 4'd7, S_OUT = 4'd8,
                           S_OLD = 4'd9;

    logic [3:0]    st_reg, st_next;
    logic [EW-1:0] mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] vld_reg;
    logic [AW-1:0] newest_reg;
    logic [AW-1:0] idx_reg, j_reg;
    logic          first_reg;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] rd_raw;
    logic          rd_v_reg;
    logic [EW-1:0] rd_data;
    logic          we;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic [1:0]    cmd_reg;
    logic [TIME_W-1:0] t_reg, tb_reg;
    logic [EW-1:0] box_in_reg, ea_reg, eb_reg;
    logic [3:0]    k_reg;
    logic [FRACTION_BITS-1:0] frac_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [COORD_BITS-1:0] acur_reg;
    logic [OUT_W-1:0] res_reg [NCOORD];
    logic [1:0]    status_reg;
    logic          mv_reg;
    div_req_t      dreq;
    div_stat_t     dstat;
    logic [FRACTION_BITS-1:0] dquot;
    logic [TIME_W-1:0] qt, now;

    assign qt  = s_tdata[30:0];
    assign now = s_tdata[61:31];
    assign s_tready = (st_reg == S_IDLE) && !mv_reg;

    // History memory with registered read.
    always_ff @(posedge aclk) begin
        if (we) mem[wr_addr] <= wr_data;
        rd_raw <= mem[rd_addr];
    end
    assign rd_data = rd_v_reg ? rd_raw : '0;

    tbhr_divider #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .req(dreq), .stat(dstat), .quot(dquot)
    );

    // Field views of entries.
    function automatic logic signed [COORD_BITS-1:0] fld(logic [EW-1:0] e,
                                                          logic [3:0] k);
        fld = e[TIME_W + k*COORD_BITS +: COORD_BITS];
    endfunction

    logic signed [COORD_BITS-1:0] fa_c, fb_c;
    logic signed [COORD_BITS:0]   diff_c;
    logic signed [PW-1:0]         mul_c;
    logic signed [PW-FRACTION_BITS-1:0] q_c;
    logic signed [COORD_BITS-1:0] sum_c;
    logic [EW-1:0] in_box;

    always_comb begin
        in_box[TIME_W-1:0] = now;
        for (int k = 0; k < NCOORD; k++) begin
            in_box[TIME_W + k*COORD_BITS +: COORD_BITS] =
                s_tdata[62 + k*21 +: COORD_BITS];
        end
        fa_c   = fld(ea_reg, k_reg);
        fb_c   = fld(eb_reg, k_reg);
        diff_c = {fb_c[COORD_BITS-1], fb_c} - {fa_c[COORD_BITS-1], fa_c};
        mul_c  = PW'(diff_c) * $signed({1'b0, frac_reg});
        q_c    = (PW-FRACTION_BITS)'(prod_reg >>> FRACTION_BITS);
        sum_c  = acur_reg + COORD_BITS'(q_c);
    end

    // Sequencer.
    always_comb begin
        st_next = st_reg;
        we = 1'b0; wr_addr = idx_reg; wr_data = box_in_reg;
        rd_addr = idx_reg;
        dreq.start = 1'b0;
        dreq.den = 32'(tb_reg - ea_reg[TIME_W-1:0]);
        dreq.num_hi = 32'(t_reg - ea_reg[TIME_W-1:0]);
        case (st_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    case (s_tuser)
                        CMD_STORE: begin
                            we = 1'b1;
                            wr_addr = (newest_reg == AW'(RING_DEPTH-1)) ? '0
                                                                       : newest_reg + 1'b1;
                            wr_data = in_box;
                            st_next = S_OUT;
                        end
                        CMD_RESET:  st_next = S_RST;
                        CMD_REWIND: st_next = S_RD;
                        default:    st_next = S_OUT;
                    endcase
                end
            end
            S_RST: begin
                we = 1'b1;
                if (idx_reg == AW'(RING_DEPTH-1)) st_next = S_OUT;
            end
            S_RD:  st_next = S_CHK;
            S_CHK: begin
                if (rd_data[TIME_W-1:0] <= t_reg) begin
                    if (first_reg) st_next = S_OUT;
                    else begin
                        rd_addr = j_reg;
                        st_next = S_RDJ;
                    end
                end else if (idx_reg == newest_reg && !first_reg) begin
                    st_next = S_OLD;
                end else begin
                    st_next = S_RD;
                end
            end
            S_RDJ: st_next = S_DIV;
            S_DIV: begin
                if (dstat.done) st_next = S_MUL;
            end
            S_MUL: st_next = S_ACC;
            S_ACC: st_next = (k_reg == 4'(NCOORD-1)) ? S_OUT : S_MUL;
            S_OLD: st_next = S_OUT;
            S_OUT: st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
        if (st_reg == S_CHK && rd_data[TIME_W-1:0] > t_reg) begin
            rd_addr = (idx_reg == '0) ? AW'(RING_DEPTH-1) : idx_reg - 1'b1;
        end
        if (st_reg == S_CHK && st_next == S_RDJ) rd_addr = j_reg;
        if (st_reg == S_CHK && st_next == S_OLD) rd_addr = j_reg;
        if (st_reg == S_IDLE) rd_addr = newest_reg;
        if (st_reg == S_RDJ) dreq.start = 1'b1;
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (st_reg == S_IDLE && s_tvalid && s_tready) begin
            cmd_reg    <= s_tuser;
            t_reg      <= (qt > now) ? now : qt;
            box_in_reg <= {in_box[EW-1:TIME_W], {TIME_W{1'b0}}};
            idx_reg    <= (s_tuser == CMD_RESET) ? '0 : newest_reg;
            first_reg  <= 1'b1;
            j_reg      <= newest_reg;
            for (int k = 0; k < NCOORD; k++) res_reg[k] <= '0;
            status_reg <= ST_NONE;
        end
        if (st_reg == S_RST) idx_reg <= idx_reg + 1'b1;
        if (st_reg == S_CHK) begin
            if (rd_data[TIME_W-1:0] <= t_reg) begin
                ea_reg <= rd_data;
            end else begin
                j_reg     <= idx_reg;
                tb_reg    <= rd_data[TIME_W-1:0];
                first_reg <= 1'b0;
                idx_reg   <= (idx_reg == '0) ? AW'(RING_DEPTH-1) : idx_reg - 1'b1;
            end
        end
        if (st_reg == S_RDJ) eb_reg <= rd_data;
        if (st_reg == S_DIV) begin
            frac_reg <= dquot;
            k_reg    <= '0;
        end
        if (st_reg == S_MUL) begin
            prod_reg <= mul_c;
            acur_reg <= fld(ea_reg, k_reg);
        end
        if (st_reg == S_ACC) begin
            res_reg[k_reg] <= OUT_W'(sum_c);
            k_reg <= k_reg + 1'b1;
            status_reg <= ST_INTERP;
        end
        if (st_reg == S_OLD) begin
            for (int k = 0; k < NCOORD; k++) res_reg[k] <= OUT_W'(fld(rd_data, 4'(k)));
            status_reg <= ST_OLDEST;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= S_IDLE;
            vld_reg    <= '0;
            newest_reg <= AW'(RING_DEPTH-1);
            mv_reg     <= 1'b0;
            rd_v_reg   <= 1'b0;
        end else begin
            st_reg   <= st_next;
            rd_v_reg <= vld_reg[rd_addr];
            if (we) vld_reg[wr_addr] <= 1'b1;
            if (st_reg == S_IDLE && s_tvalid && s_tready && s_tuser == CMD_STORE)
                newest_reg <= wr_addr;
            if (st_reg == S_RST) newest_reg <= AW'(RING_DEPTH-1);
            if (st_reg == S_OUT) mv_reg <= 1'b1;
            else if (m_tready) mv_reg <= 1'b0;
        end
    end

    always_comb begin
        m_tdata = '0;
        for (int k = 0; k < NCOORD; k++) m_tdata[k*21 +: 21] = res_reg[k];
    end
    assign m_tuser  = status_reg;
    assign m_tvalid = mv_reg;

    `include "timestamped_box_history_rewind_assert.svh"
    `TBHR_ASSERT_IMP(a_busy_not_ready, aclk, aresetn, st_reg != S_IDLE, !s_tready,
        "input ready while busy")
    `TBHR_ASSERT_NXT(a_out_after_done, aclk, aresetn, st_reg == S_OUT, m_tvalid,
        "result not presented")
    `TBHR_ASSERT_IMP(a_div_only_in_div, aclk, aresetn, dstat.busy,
        st_reg == S_DIV, "divider busy outside divide step")
    `TBHR_ASSERT_IMP(a_interp_status, aclk, aresetn,
        m_tvalid && m_tuser == ST_INTERP, cmd_reg == CMD_REWIND,
        "interpolated result without rewind")
endmodule
`default_nettype wire

// ===== src/tbhr_divider.sv =====
// ----------------------------------------------------------------------------
// tbhr_divider
// Restoring divider, one quotient bit per cycle: (num_hi << FB) / den.
// ----------------------------------------------------------------------------
`default_nettype none
module tbhr_divider
    import tbhr_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire div_req_t                 req,
    output div_stat_t                     stat,
    output logic [FRACTION_BITS-1:0]      quot
);
    localparam int NW = 32 + FRACTION_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg, num_next;
    logic [32:0]   rem_reg, rem_next;
    logic [31:0]   den_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [32:0]   shifted;
    logic [33:0]   diff;

    // One shift-and-subtract step per cycle.
    always_comb begin
        shifted   = {rem_reg[31:0], num_reg[NW-1]};
        diff      = {1'b0, shifted} - {2'b0, den_reg};
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            num_next  = {req.num_hi, {FRACTION_BITS{1'b0}}};
            rem_next  = '0;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[NW-2:0], ~diff[33]};
            rem_next = diff[33] ? shifted : diff[32:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) den_reg <= req.den;
        num_reg <= num_next;
        rem_reg <= rem_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = num_reg[FRACTION_BITS-1:0];
endmodule
`default_nettype wire

// ===== bench/box_history_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_history_checker
// Watches both channels of the box history ring, keeps its own copy of the
// ring, predicts every result and compares its status and whole data word.
// ----------------------------------------------------------------------------
`default_nettype none
module box_history_checker
    import tbhr_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [255:0] s_tdata,
    input  wire logic [1:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [191:0] m_tdata,
    input  wire logic [1:0]   m_tuser,
    output int                fail_count,
    output int                pending_count
);
    localparam int DEPTH = RING_DEPTH_DEF;
    localparam int FB    = FRACTION_BITS_DEF;

    typedef logic signed [OUT_W-1:0] coord_t;
    typedef struct packed {
        logic [1:0] status;
        logic [191:0] box;
    } rewind_answer_t;

    logic [TIME_W-1:0] ring_stamp [DEPTH];
    coord_t            ring_box   [DEPTH][NCOORD];
    int                newest;
    rewind_answer_t    answers_due [$];

    assign pending_count = answers_due.size();

    // Blend one coordinate toward the newer entry, rounding toward minus infinity.
    function automatic coord_t blend_coord(coord_t a, coord_t b, longint frac);
        longint prod;
        prod = (longint'(b) - longint'(a)) * frac;
        return coord_t'(longint'(a) + (prod >>> FB));
    endfunction

    // Apply one accepted transfer to the ring and return its answer.
    function automatic rewind_answer_t apply_command(logic [1:0] cmd, logic [255:0] d);
        rewind_answer_t ans;
        logic [TIME_W-1:0] qt, now, t;
        coord_t inbox [NCOORD];
        int i, j;
        longint frac;
        ans = '0;
        qt  = d[30:0];
        now = d[61:31];
        for (int k = 0; k < NCOORD; k++) inbox[k] = d[62 + 21*k +: 21];
        if (cmd == CMD_STORE) begin
            newest = (newest + 1) % DEPTH;
            ring_stamp[newest] = now;
            for (int k = 0; k < NCOORD; k++) ring_box[newest][k] = inbox[k];
        end else if (cmd == CMD_RESET) begin
            for (int s = 0; s < DEPTH; s++) begin
                ring_stamp[s] = '0;
                for (int k = 0; k < NCOORD; k++) ring_box[s][k] = inbox[k];
            end
            newest = DEPTH - 1;
        end else if (cmd == CMD_REWIND) begin
            t = (qt > now) ? now : qt;
            i = newest;
            j = newest;
            do begin
                if (ring_stamp[i] <= t) break;
                j = i;
                i = (i == 0) ? DEPTH - 1 : i - 1;
            end while (i != newest);
            if (i != j) begin
                if (i != newest) begin
                    frac = ((longint'(t) - longint'(ring_stamp[i])) << FB) /
                           (longint'(ring_stamp[j]) - longint'(ring_stamp[i]));
                    for (int k = 0; k < NCOORD; k++)
                        ans.box[21*k +: 21] = blend_coord(ring_box[i][k], ring_box[j][k], frac);
                    ans.status = ST_INTERP;
                end else begin
                    for (int k = 0; k < NCOORD; k++) ans.box[21*k +: 21] = ring_box[j][k];
                    ans.status = ST_OLDEST;
                end
            end
        end
        return ans;
    endfunction

    // Predict on input transfers, compare on output transfers.
    always_ff @(posedge aclk) begin
        rewind_answer_t want;
        if (!aresetn) begin
            for (int s = 0; s < DEPTH; s++) begin
                ring_stamp[s] = '0;
                for (int k = 0; k < NCOORD; k++) ring_box[s][k] = '0;
            end
            newest = DEPTH - 1;
            fail_count <= 0;
            answers_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected result status %0d data %h", $time,
                             m_tuser, m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = answers_due.pop_front();
                    if (want.status !== m_tuser || want.box !== m_tdata) begin
                        $display("%0t: expected status %0d data %h, got status %0d data %h",
                                 $time, want.status, want.box, m_tuser, m_tdata);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                answers_due.push_back(apply_command(s_tuser, s_tdata));
        end
    end
endmodule
`default_nettype wire

// ===== bench/tb_timestamped_box_history_rewind.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timestamped_box_history_rewind
// Drives stores, ring resets, rewinds and spare commands at the box history ring
// with random stalls on both sides and reports the verdict of the checker.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_timestamped_box_history_rewind
    import tbhr_pkg::*;
();
    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [255:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;
    logic [1:0]   m_tuser;
    int           fail_count;
    int           pending_count;
    int           cycle_count = 0;
    bit           quiet_phase;
    bit           hold_off;
    logic [30:0]  clock_ms;

    timestamped_box_history_rewind i_dut (.*);

    box_history_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, a long hold-off when asked.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            m_tready <= !hold_off && (quiet_phase || $urandom_range(99) >= 9);
        end
    end

    initial begin
        hold_off = 1'b0;
        wait (cycle_count == 3000);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (1500) @(posedge aclk);
        hold_off <= 1'b0;
    end

    function automatic logic [20:0] rand_coord();
        case ($urandom_range(5))
            0: return 21'h100000;
            1: return 21'h0FFFFF;
            2: return 21'($urandom_range(40)) - 21'd20;
            default: return 21'($urandom);
        endcase
    endfunction

    // Send one transfer and wait for its acceptance.
    task automatic send_item(logic [1:0] cmd, logic [30:0] qt, logic [30:0] now,
                             bit extreme);
        logic [255:0] d;
        d = '0;
        d[30:0]  = qt;
        d[61:31] = now;
        for (int k = 0; k < NCOORD; k++)
            d[62 + 21*k +: 21] = extreme ? ((k % 2) ? 21'h100000 : 21'h0FFFFF) : rand_coord();
        while (!quiet_phase && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    initial begin
        logic [30:0] step;
        int pick;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        aresetn  = 1'b0;
        quiet_phase = 1'b0;
        clock_ms = 31'd100;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: rewinds on the empty ring, extremes, unused command, then stores and rewinds.
        send_item(CMD_REWIND, 31'd0, 31'd0, 1'b0);
        send_item(CMD_REWIND, 31'h7FFFFFFF, 31'h7FFFFFFF, 1'b0);
        send_item(CMD_RESET, 31'h7FFFFFFF, 31'h7FFFFFFF, 1'b1);
        send_item(CMD_SPARE, 31'h7FFFFFFF, 31'h7FFFFFFF, 1'b0);
        for (int n = 0; n < 4; n++) send_item(CMD_STORE, 31'd0, 31'(10 * (n + 1)), n == 0);
        send_item(CMD_REWIND, 31'd40, 31'd50, 1'b0);
        send_item(CMD_REWIND, 31'd25, 31'd50, 1'b0);
        send_item(CMD_REWIND, 31'd13, 31'd17, 1'b0);
        send_item(CMD_REWIND, 31'd0, 31'd0, 1'b0);
        send_item(CMD_STORE, 31'd0, 31'h7FFFFFFF, 1'b1);
        send_item(CMD_REWIND, 31'h7FFFFFFE, 31'h7FFFFFFF, 1'b0);
        send_item(CMD_REWIND, 31'h7FFFFFFF, 31'h7FFFFFFE, 1'b0);
        send_item(CMD_STORE, 31'd0, 31'd5, 1'b0);
        send_item(CMD_REWIND, 31'd20, 31'd4, 1'b0);
        send_item(CMD_RESET, 31'd0, 31'd0, 1'b0);

        // Random part: mostly rising stores and rewinds into the recent past.
        clock_ms = 31'd50;
        for (int n = 0; n < 2000; n++) begin
            quiet_phase = (n >= 600 && n < 800);
            pick = $urandom_range(99);
            if (n % 500 == 499) clock_ms = 31'h7FFFFF00 - 31'($urandom_range(5000));
            step = 31'($urandom_range(40));
            if (pick < 45) begin
                clock_ms = clock_ms + step + 31'd1;
                if (clock_ms[30] && !clock_ms[29]) clock_ms = 31'($urandom_range(100));
                send_item(CMD_STORE, 31'($urandom), ($urandom_range(19) == 0) ?
                          31'($urandom) : clock_ms, 1'b0);
            end else if (pick < 90) begin
                send_item(CMD_REWIND, clock_ms - 31'($urandom_range(600)),
                          clock_ms + 31'($urandom_range(3)), 1'b0);
            end else if (pick < 95) begin
                send_item(CMD_REWIND, 31'($urandom), 31'($urandom), 1'b0);
            end else if (pick < 98) begin
                send_item(CMD_RESET, 31'($urandom), 31'($urandom), 1'b0);
            end else begin
                send_item(CMD_SPARE, 31'($urandom), 31'($urandom), 1'b0);
            end
        end
        s_tvalid <= 1'b0;

        // Let the checker record the last transfer before draining.
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
